FILE: hdl/tsf_pkg.sv
// Shared types, codes and sizes for the topic subscription fanout block.
`default_nettype none

package tsf_pkg;

  // Default number of table entries.
  localparam int TSF_TABLE_DEPTH = 64;

  // Field widths.
  localparam int TOPIC_W = 64;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int KIND_W  = 2;

  // One table entry: topic key, then address and port.
  localparam int ENTRY_W = TOPIC_W + IP_W + PORT_W;

  // Request type codes.
  localparam logic REQ_SUBSCRIBE = 1'b0;
  localparam logic REQ_PUBLISH   = 1'b1;

  // Result kind codes.
  localparam logic [KIND_W-1:0] KIND_SUBSCRIBED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORWARD    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE       = 2'd3;

  // Incoming request.
  typedef struct packed {
    logic               req_type;
    logic [TOPIC_W-1:0] topic_key;
    logic [IP_W-1:0]    sub_ip;
    logic [PORT_W-1:0]  sub_port;
  } tsf_in_t;

  // Outgoing result.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic              last;
  } tsf_out_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic     valid;
    tsf_out_t res;
  } tsf_push_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tsf_state_t;

endpackage

`default_nettype wire

FILE: hdl/tsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tsf_seq.sv
// Sequencer: appends subscriptions and scans the table for each publish.
`default_nettype none

module tsf_seq #(
  parameter int TABLE_DEPTH = tsf_pkg::TSF_TABLE_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire tsf_pkg::tsf_in_t             in_data,
  output logic                              in_stall,
  input  wire logic                         can_push,
  output tsf_pkg::tsf_push_t                push,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [tsf_pkg::ENTRY_W-1:0]       wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  wire logic [tsf_pkg::ENTRY_W-1:0]  rd_data
);

  import tsf_pkg::*;

  tsf_state_t                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [TOPIC_W-1:0]         key_r, key_nxt;
  logic [KIND_W-1:0]          kind_r, kind_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  logic [IP_W+PORT_W-1:0]     pend_dest_r, pend_dest_nxt;

  logic                       accept;
  logic                       match;
  logic                       last_idx;
  logic [TOPIC_W-1:0]         rd_topic;
  logic [IP_W+PORT_W-1:0]     rd_dest;

  assign rd_topic = rd_data[ENTRY_W-1 -: TOPIC_W];
  assign rd_dest  = rd_data[IP_W+PORT_W-1:0];
  assign match    = (rd_topic == key_r);
  assign last_idx = ({{(CW-AW){1'b0}}, idx_r} == (count_r - CW'(1)));

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    kind_r      <= kind_nxt;
    pend_dest_r <= pend_dest_nxt;
  end

  // Next state, memory accesses and result pushes.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    kind_nxt       = kind_r;
    pend_valid_nxt = pend_valid_r;
    pend_dest_nxt  = pend_dest_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = {in_data.topic_key, in_data.sub_ip, in_data.sub_port};
    rd_en          = 1'b0;
    rd_addr        = '0;
    push           = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_SUBSCRIBE) begin
            // Append while there is room, otherwise report a full table.
            if (count_r < CW'(TABLE_DEPTH)) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
              kind_nxt  = KIND_SUBSCRIBED;
            end else begin
              kind_nxt  = KIND_FULL;
            end
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_FINISH;
          end else begin
            // Start the scan at the oldest entry.
            key_nxt        = in_data.topic_key;
            kind_nxt       = KIND_NONE;
            pend_valid_nxt = 1'b0;
            idx_nxt        = '0;
            if (count_r == '0) begin
              state_nxt = ST_FINISH;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // A new match sends the held one out, which needs the output register.
        if (!(match && pend_valid_r && !can_push)) begin
          if (match) begin
            if (pend_valid_r) begin
              push.valid         = 1'b1;
              push.res.kind      = KIND_FORWARD;
              push.res.dest_ip   = pend_dest_r[IP_W+PORT_W-1:PORT_W];
              push.res.dest_port = pend_dest_r[PORT_W-1:0];
              push.res.last      = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_dest_nxt  = rd_dest;
          end
          if (last_idx) begin
            state_nxt = ST_FINISH;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end

      ST_FINISH: begin
        // Final result: the held match, or the status of the request.
        if (can_push) begin
          push.valid = 1'b1;
          push.res.last = 1'b1;
          if (pend_valid_r) begin
            push.res.kind      = KIND_FORWARD;
            push.res.dest_ip   = pend_dest_r[IP_W+PORT_W-1:PORT_W];
            push.res.dest_port = pend_dest_r[PORT_W-1:0];
          end else begin
            push.res.kind = kind_r;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/topic_subscription_fanout.sv
// Top level of the topic subscription fanout block.
//
// A subscribe request appends its topic key, address and port to a table of
// TABLE_DEPTH entries held in one synchronous RAM, and answers with one
// "subscribed" result, or "table full" once every entry is taken. A publish
// request reads the stored entries oldest first, one entry per cycle through
// the RAM read port unless a stalled output pauses the scan, and emits one
// forward result per entry with an equal key (duplicates included), the final
// one marked last; with no match it emits a single "no subscribers" result.
// The scan rate is bound by the single RAM read port. One request is processed
// at a time, and a finished result can wait in the output register while the
// next request is taken. Only reset empties the table.
`default_nettype none

module topic_subscription_fanout #(
  parameter int TABLE_DEPTH = tsf_pkg::TSF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tsf_pkg::tsf_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tsf_pkg::tsf_out_t     out_data
);

  import tsf_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tsf_push_t            push;
  logic                 can_push;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 out_valid_r, out_valid_nxt;
  tsf_out_t             out_data_r, out_data_nxt;

  // Subscription table.
  tsf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request sequencer.
  tsf_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .can_push (can_push),
    .push     (push),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Output register: free when empty or being taken this cycle.
  assign can_push = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
